@@ hw/rtl/mcr_pkg.sv @@
// Shared types and constants for the midpoint circle rasterizer.
// Used by the front end, the octet queue, the point emitter and the top level.
package mcr_pkg;

  // Width of an emitted coordinate; points wrap to this many bits.
  localparam int unsigned COORD_BITS = 12;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned POINTS   = 8;
  localparam int unsigned PIDX_W   = $clog2(POINTS);

  // Input item kinds carried in tuser.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // One step's worth of work: the centre, the offset and the flags of its octet.
  typedef struct packed {
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic [9:0]         ox;
    logic [9:0]         oy;
    logic               done;
    logic               live;
  } octet_t;

endpackage

@@ hw/rtl/mcr_front.sv @@
// Front end of the circle rasterizer: holds the circle state, takes start and
// step beats and pushes one octet descriptor per step. Depends on mcr_pkg.
module mcr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mcr_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [mcr_pkg::IN_USER_W-1:0]  in_user_i,
  output logic                           push_o,
  output mcr_pkg::octet_t                push_data_o,
  input  logic                           full_i
);

  logic [9:0]         ox_q, ox_d, oy_q, oy_d;
  logic signed [13:0] dec_q, dec_d;
  logic signed [10:0] cx_q, cx_d, cy_q, cy_d;
  logic               active_q, active_d;

  logic               accept;
  logic               is_step;
  logic signed [10:0] in_cx, in_cy;
  logic [9:0]         in_r;
  logic signed [13:0] diff, inc;
  logic signed [11:0] nx, ny;
  logic               done;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_step    = (in_user_i[0] == mcr_pkg::ACT_STEP);

  assign in_cx = $signed(in_data_i[10:0]);
  assign in_cy = $signed(in_data_i[21:11]);
  assign in_r  = in_data_i[31:22];

  // The update uses the offset before it advances.
  always_comb begin
    diff = $signed({4'b0000, ox_q}) - $signed({4'b0000, oy_q});
    if (dec_q[13]) begin
      inc = 14'sd6 + $signed({2'b00, ox_q, 2'b00});
      ny  = $signed({2'b00, oy_q});
    end else begin
      inc = 14'sd10 + (diff <<< 2);
      ny  = $signed({2'b00, oy_q}) - 12'sd1;
    end
    nx   = $signed({2'b00, ox_q}) + 12'sd1;
    done = nx > ny;
  end

  always_comb begin
    ox_d     = ox_q;
    oy_d     = oy_q;
    dec_d    = dec_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    active_d = active_q;
    if (accept) begin
      if (!is_step) begin
        cx_d     = in_cx;
        cy_d     = in_cy;
        ox_d     = '0;
        oy_d     = in_r;
        dec_d    = 14'sd3 - $signed({3'b000, in_r, 1'b0});
        active_d = 1'b1;
      end else if (active_q) begin
        dec_d = dec_q + inc;
        ox_d  = nx[9:0];
        oy_d  = ny[9:0];
        if (done) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q     <= '0;
      oy_q     <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      active_q <= 1'b0;
    end else begin
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      dec_q    <= dec_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      active_q <= active_d;
    end
  end

  assign push_o           = accept && is_step;
  assign push_data_o.cx   = cx_q;
  assign push_data_o.cy   = cy_q;
  assign push_data_o.ox   = ox_q;
  assign push_data_o.oy   = oy_q;
  assign push_data_o.done = done;
  assign push_data_o.live = active_q;

endmodule

@@ hw/rtl/mcr_queue.sv @@
// Short queue of octet descriptors between the front end and the emitter.
// Depends on mcr_pkg for its depth and entry type.
module mcr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcr_pkg::octet_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mcr_pkg::octet_t head_o
);

  mcr_pkg::octet_t                 mem_q [mcr_pkg::QUEUE_DEPTH];
  logic [mcr_pkg::QPTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [mcr_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == mcr_pkg::QCNT_W'(mcr_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  function automatic logic [mcr_pkg::QPTR_W-1:0] nxt(input logic [mcr_pkg::QPTR_W-1:0] p);
    if (p == mcr_pkg::QPTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_d  = push_i ? nxt(wr_q) : wr_q;
    rd_d  = pop_i ? nxt(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/mcr_back.sv @@
// Point emitter: walks the eight symmetric points of the head octet into an
// output register, one point per beat. Depends on mcr_pkg.
module mcr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            head_valid_i,
  input  mcr_pkg::octet_t                 head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mcr_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic [mcr_pkg::OUT_USER_W-1:0]  out_user_o,
  output logic                            out_last_o
);

  logic [mcr_pkg::PIDX_W-1:0]          idx_q, idx_d;
  logic                                ov_q, ov_d;
  logic signed [mcr_pkg::COORD_BITS-1:0] px_q, py_q;
  logic                                pv_q, last_q, done_q;

  logic                                load;
  logic                                swap, neg_a, neg_b, final_pt;
  logic signed [mcr_pkg::COORD_BITS-1:0] cx, cy, a, b, sx, sy;

  assign load     = head_valid_i && (!ov_q || out_ready_i);
  assign final_pt = (idx_q == mcr_pkg::PIDX_W'(mcr_pkg::POINTS - 1));
  assign pop_o    = load && (!head_i.live || final_pt);

  // Points 1, 2, 5 and 6 swap x and y; the last four negate the first term,
  // and points 2 to 5 negate the second.
  always_comb begin
    swap  = (idx_q[1] ^ idx_q[0]);
    neg_a = idx_q[2];
    neg_b = (idx_q[2] ^ idx_q[1]);
    cx    = mcr_pkg::COORD_BITS'(head_i.cx);
    cy    = mcr_pkg::COORD_BITS'(head_i.cy);
    a     = $signed(mcr_pkg::COORD_BITS'(swap ? head_i.oy : head_i.ox));
    b     = $signed(mcr_pkg::COORD_BITS'(swap ? head_i.ox : head_i.oy));
    sx    = neg_a ? cx - a : cx + a;
    sy    = neg_b ? cy - b : cy + b;
  end

  always_comb begin
    ov_d  = ov_q;
    idx_d = idx_q;
    if (load) begin
      ov_d = 1'b1;
      if (head_i.live) begin
        idx_d = final_pt ? '0 : idx_q + 1'b1;
      end
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      ov_q  <= ov_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.live) begin
        px_q   <= sx;
        py_q   <= sy;
        pv_q   <= 1'b1;
        last_q <= final_pt;
        done_q <= head_i.done;
      end else begin
        px_q   <= '0;
        py_q   <= '0;
        pv_q   <= 1'b0;
        last_q <= 1'b1;
        done_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = mcr_pkg::OUT_DATA_W'({py_q, px_q});
  assign out_user_o  = {done_q, pv_q};
  assign out_last_o  = last_q;

endmodule

@@ hw/rtl/midpoint_circle_rasterizer_top.sv @@
// Top level of the midpoint circle rasterizer: front end, octet queue and
// point emitter. Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
//
//  Channel  Dir  Beat contents
//  s_axis   in   tuser: action; tdata: center_x, center_y, radius
//  m_axis   out  tuser: point_valid, circle_done; tdata: point_x, point_y; tlast: last_of_octet
//
// A start beat is taken and yields nothing. A step beat yields eight point beats, one
// per cycle from the emitter's output register while m_axis_tready is high, so a steady
// stream of steps is paced by the emitter; a step while idle yields one beat.
// The two-entry octet queue lets the input side run ahead of the emitter.
// Reset is asynchronous and active low and leaves the generator idle.
module midpoint_circle_rasterizer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [10:0] center_x, [21:11] center_y, [31:22] radius
  input  logic [mcr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  logic [mcr_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [11:0] point_x, [23:12] point_y
  output logic [mcr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] point_valid, [1] circle_done
  output logic [mcr_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                           m_axis_tlast
);

  logic            push, full, pop, head_valid;
  mcr_pkg::octet_t push_data, head;

  mcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  mcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  mcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule
